/* hw/rtl/est_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the edge statistics table.
package est_pkg;

  localparam int NODE_W = 16;
  localparam int STAT_W = 32;
  localparam int CONF_W = 15;
  localparam int USED_W = 7;

  // Observation count saturates here.
  localparam logic [STAT_W-1:0] HITS_MAX   = 32'hFFFF_FFFF;
  // Confidence is n * CONF_SCALE / (n + CONF_BIAS), capped at CONF_CAP.
  localparam logic [STAT_W-1:0] CONF_SCALE = 32'd16000;
  localparam logic [STAT_W:0]   CONF_BIAS  = 33'd100;
  localparam logic [CONF_W-1:0] CONF_CAP   = 15'd16384;

  // The divider produces one quotient bit per cycle; this is the last step.
  localparam logic [4:0] DIV_LAST = 5'd31;

  localparam logic MODE_OBSERVE = 1'b0;
  localparam logic MODE_LOOKUP  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SELF      = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
    logic [STAT_W-1:0] latency_sample;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [STAT_W-1:0] hit_count;
    logic [STAT_W-1:0] mean_latency;
    logic [CONF_W-1:0] confidence;
    logic [USED_W-1:0] entries_used;
  } out_item_t;

  // One stored edge.
  typedef struct packed {
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
    logic [STAT_W-1:0] hit_count;
    logic [STAT_W-1:0] mean_latency;
    logic [CONF_W-1:0] confidence;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_PREP,
    S_MEAN_MUL,
    S_MEAN_ADD,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_CONF_MUL,
    S_CONF_GO,
    S_CONF_WAIT,
    S_WRITE,
    S_OUT
  } state_t;

endpackage

/* hw/rtl/est_div.sv */
`timescale 1ns / 1ps
// Shared restoring divider: 64-bit dividend, 33-bit divisor, 32 quotient bits.
module est_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] numer,
  input  logic [32:0] denom,
  output logic        busy,
  output logic        done,
  output logic [31:0] quot
);

  // The caller guarantees numer < denom * 2**32, so the quotient fits 32 bits.
  logic [33:0] rem;
  logic [31:0] lo;
  logic [32:0] den;
  logic [4:0]  cnt;
  logic [33:0] trial;
  logic        ge;

  assign trial = {rem[32:0], lo[31]};
  assign ge    = (trial >= {1'b0, den});
  assign quot  = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == est_pkg::DIV_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == est_pkg::DIV_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {2'b00, numer[63:32]};
      lo  <= numer[31:0];
      den <= denom;
    end else if (busy) begin
      rem <= ge ? (trial - {1'b0, den}) : trial;
      lo  <= {lo[30:0], ge};
    end
  end

endmodule

/* hw/rtl/est_mem.sv */
`timescale 1ns / 1ps
// Edge store: one write port and one registered read port.
module est_mem #(
  parameter int EDGE_ENTRIES = 64,
  parameter int IW           = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IW-1:0]    waddr,
  input  est_pkg::entry_t  wdata,
  input  logic [IW-1:0]    raddr,
  output est_pkg::entry_t  rdata
);

  est_pkg::entry_t mem [EDGE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/edge_statistics_table.sv */
`timescale 1ns / 1ps
// Edge statistics table top level: sequencer, shared multiplier, edge store and divider.
// Lookup time is set by the search, which reads one entry per cycle.
// Observe adds two divisions to the search, one for the mean and one for the confidence.
// One transaction is worked on at a time; the next is taken once the result is registered.
// Reset (synchronous, rst high) empties the table; entries are never read before written.
module edge_statistics_table #(
  parameter int EDGE_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  est_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output est_pkg::out_item_t  out_data
);

  // Index width covers the entries; the count also needs to hold EDGE_ENTRIES itself.
  localparam int IW = (EDGE_ENTRIES > 1) ? $clog2(EDGE_ENTRIES) : 1;
  localparam int CW = $clog2(EDGE_ENTRIES + 1);

  est_pkg::state_t state, state_next;

  // Transaction held while it is worked on.
  logic                           mode_r;
  logic [est_pkg::NODE_W-1:0]     src_r;
  logic [est_pkg::NODE_W-1:0]     dst_r;
  logic [est_pkg::STAT_W-1:0]     sample_r;
  logic [1:0]                     status_r;

  // Table occupancy and search pointers.
  logic [CW-1:0]                  used_count;
  logic [CW-1:0]                  ptr;
  logic                           chk_v;
  logic [IW-1:0]                  chk_idx;
  logic [IW-1:0]                  idx_r;
  logic                           is_new;

  // Working copy of the edge and arithmetic registers.
  est_pkg::entry_t                entry_r;
  est_pkg::entry_t                rdata;
  logic [est_pkg::STAT_W-1:0]     n_r;
  logic [est_pkg::STAT_W-1:0]     nm1_r;
  logic [63:0]                    num_r;

  // Shared multiplier and divider hookup.
  logic [est_pkg::STAT_W-1:0]     mul_a;
  logic [est_pkg::STAT_W-1:0]     mul_b;
  logic [63:0]                    mul_p;
  logic                           div_start;
  logic                           div_busy;
  logic                           div_done;
  logic [63:0]                    div_numer;
  logic [32:0]                    div_denom;
  logic [31:0]                    div_quot;
  logic [est_pkg::CONF_W-1:0]     conf_capped;

  logic                           mem_we;
  logic                           match;
  logic                           search_end;
  logic                           table_full;
  logic                           out_free;
  logic [est_pkg::STAT_W-1:0]     n_c;
  logic [CW+6:0]                  used_ext;

  // The registered read data belongs to the entry addressed in the cycle before (chk_idx).
  assign match      = chk_v && (rdata.src_node == src_r) && (rdata.dst_node == dst_r);
  assign search_end = (ptr == used_count) && !chk_v;
  assign table_full = (used_count == CW'(EDGE_ENTRIES));
  assign out_free   = !out_valid || out_ready;
  assign n_c        = (entry_r.hit_count == est_pkg::HITS_MAX) ?
                      entry_r.hit_count : (entry_r.hit_count + 32'd1);
  assign used_ext   = {7'd0, used_count};
  assign mul_p      = mul_a * mul_b;
  assign conf_capped = (div_quot > 32'(est_pkg::CONF_CAP)) ?
                       est_pkg::CONF_CAP : div_quot[est_pkg::CONF_W-1:0];

  est_mem #(
    .EDGE_ENTRIES (EDGE_ENTRIES),
    .IW           (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx_r),
    .wdata (entry_r),
    .raddr (ptr[IW-1:0]),
    .rdata (rdata)
  );

  est_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= est_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state plus the controls of the shared units.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    mem_we     = 1'b0;
    mul_a      = entry_r.mean_latency;
    mul_b      = nm1_r;
    div_numer  = num_r;
    div_denom  = {1'b0, n_r};
    case (state)
      est_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // A self edge in observe mode is rejected without a search.
          if ((in_data.mode == est_pkg::MODE_OBSERVE) &&
              (in_data.src_node == in_data.dst_node)) begin
            state_next = est_pkg::S_OUT;
          end else begin
            state_next = est_pkg::S_SEARCH;
          end
        end
      end
      est_pkg::S_SEARCH: begin
        if (match) begin
          state_next = (mode_r == est_pkg::MODE_LOOKUP) ? est_pkg::S_OUT : est_pkg::S_PREP;
        end else if (search_end) begin
          if ((mode_r == est_pkg::MODE_LOOKUP) || table_full) begin
            state_next = est_pkg::S_OUT;
          end else begin
            state_next = est_pkg::S_PREP;
          end
        end
      end
      est_pkg::S_PREP:     state_next = est_pkg::S_MEAN_MUL;
      est_pkg::S_MEAN_MUL: state_next = est_pkg::S_MEAN_ADD;
      est_pkg::S_MEAN_ADD: state_next = est_pkg::S_MEAN_GO;
      est_pkg::S_MEAN_GO: begin
        div_start  = 1'b1;
        state_next = est_pkg::S_MEAN_WAIT;
      end
      est_pkg::S_MEAN_WAIT: begin
        if (div_done) begin
          state_next = est_pkg::S_CONF_MUL;
        end
      end
      est_pkg::S_CONF_MUL: begin
        mul_a      = n_r;
        mul_b      = est_pkg::CONF_SCALE;
        state_next = est_pkg::S_CONF_GO;
      end
      est_pkg::S_CONF_GO: begin
        div_start  = 1'b1;
        div_denom  = {1'b0, n_r} + est_pkg::CONF_BIAS;
        state_next = est_pkg::S_CONF_WAIT;
      end
      est_pkg::S_CONF_WAIT: begin
        if (div_done) begin
          state_next = est_pkg::S_WRITE;
        end
      end
      est_pkg::S_WRITE: begin
        mem_we     = 1'b1;
        state_next = est_pkg::S_OUT;
      end
      est_pkg::S_OUT: begin
        if (out_free) begin
          state_next = est_pkg::S_IDLE;
        end
      end
      default: state_next = est_pkg::S_IDLE;
    endcase
  end

  // Control registers: occupancy, search progress and the output flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      chk_v      <= 1'b0;
      ptr        <= '0;
      out_valid  <= 1'b0;
    end else begin
      // A new result may replace the one taken in the same cycle.
      if ((state == est_pkg::S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        est_pkg::S_IDLE: begin
          ptr   <= '0;
          chk_v <= 1'b0;
        end
        est_pkg::S_SEARCH: begin
          // Issue one read per cycle and compare the previous one.
          if ((ptr != used_count) && !match) begin
            ptr   <= ptr + CW'(1);
            chk_v <= 1'b1;
          end else begin
            chk_v <= 1'b0;
          end
        end
        est_pkg::S_WRITE: begin
          if (is_new) begin
            used_count <= used_count + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      est_pkg::S_IDLE: begin
        mode_r   <= in_data.mode;
        src_r    <= in_data.src_node;
        dst_r    <= in_data.dst_node;
        sample_r <= in_data.latency_sample;
        status_r <= est_pkg::ST_SELF;
      end
      est_pkg::S_SEARCH: begin
        chk_idx <= ptr[IW-1:0];
        if (match) begin
          entry_r  <= rdata;
          idx_r    <= chk_idx;
          is_new   <= 1'b0;
          status_r <= est_pkg::ST_OK;
        end else if (search_end) begin
          // A new edge starts with zero statistics in the next free slot.
          entry_r.src_node     <= src_r;
          entry_r.dst_node     <= dst_r;
          entry_r.hit_count    <= '0;
          entry_r.mean_latency <= '0;
          entry_r.confidence   <= '0;
          idx_r                <= used_count[IW-1:0];
          is_new               <= 1'b1;
          if (mode_r == est_pkg::MODE_LOOKUP) begin
            status_r <= est_pkg::ST_NOT_FOUND;
          end else if (table_full) begin
            status_r <= est_pkg::ST_FULL;
          end else begin
            status_r <= est_pkg::ST_OK;
          end
        end
      end
      est_pkg::S_PREP: begin
        n_r   <= n_c;
        nm1_r <= n_c - 32'd1;
      end
      est_pkg::S_MEAN_MUL: num_r <= mul_p;
      est_pkg::S_MEAN_ADD: num_r <= num_r + {32'd0, sample_r};
      est_pkg::S_MEAN_WAIT: begin
        if (div_done) begin
          entry_r.mean_latency <= div_quot;
        end
      end
      est_pkg::S_CONF_MUL: begin
        num_r             <= mul_p;
        entry_r.hit_count <= n_r;
      end
      est_pkg::S_CONF_WAIT: begin
        if (div_done) begin
          entry_r.confidence <= conf_capped;
        end
      end
      est_pkg::S_OUT: begin
        if (out_free) begin
          out_data.status       <= status_r;
          out_data.entries_used <= used_ext[6:0];
          if (status_r == est_pkg::ST_OK) begin
            out_data.hit_count    <= entry_r.hit_count;
            out_data.mean_latency <= entry_r.mean_latency;
            out_data.confidence   <= entry_r.confidence;
          end else begin
            out_data.hit_count    <= '0;
            out_data.mean_latency <= '0;
            out_data.confidence   <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  // The table never holds more edges than it has slots.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CW'(EDGE_ENTRIES))
    else $error("edge count exceeds table size");

  // The divider is only started when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // A new result only appears out of the output state.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == est_pkg::S_OUT)
    else $error("result produced outside output state");

  // Rejected or missing edges report a zero hit count and zero confidence.
  a_zero_stats: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status != est_pkg::ST_OK)) |->
      ((out_data.hit_count == '0) && (out_data.confidence == '0)))
    else $error("nonzero statistics on a failed transaction");

  // Confidence stays within its cap.
  a_conf_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.confidence <= est_pkg::CONF_CAP)
    else $error("confidence above cap");

endmodule

/* tb/edge_table_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the edge statistics table: a private copy of the table and result comparison.
module edge_table_checker #(
  parameter int SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  est_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  est_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending,
  output int                 results_checked,
  output int                 table_fill
);

  localparam logic [63:0] COUNT_TOP  = 64'hFFFF_FFFF;
  localparam logic [63:0] CONF_NUM   = 64'd16000;
  localparam logic [63:0] CONF_ADD   = 64'd100;
  localparam logic [63:0] CONF_LIMIT = 64'd16384;

  logic [15:0]        slot_src  [SLOTS];
  logic [15:0]        slot_dst  [SLOTS];
  logic [31:0]        slot_hits [SLOTS];
  logic [31:0]        slot_mean [SLOTS];
  logic [14:0]        slot_conf [SLOTS];
  int                 stored_edges;
  est_pkg::out_item_t queued_stats [$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    table_fill      = 0;
    stored_edges    = 0;
  end

  // Applies one transaction to the private table and returns the statistics it reports.
  function automatic est_pkg::out_item_t edge_stats_after(est_pkg::in_item_t req);
    est_pkg::out_item_t res;
    int                 slot;
    logic [63:0]        n;
    logic [63:0]        acc;
    res  = '0;
    slot = -1;
    for (int i = 0; i < stored_edges; i++) begin
      if (slot < 0 && slot_src[i] == req.src_node && slot_dst[i] == req.dst_node)
        slot = i;
    end
    if (req.mode == est_pkg::MODE_LOOKUP) begin
      res.status = (slot >= 0) ? est_pkg::ST_OK : est_pkg::ST_NOT_FOUND;
    end else if (req.src_node == req.dst_node) begin
      res.status = est_pkg::ST_SELF;
    end else if (slot < 0 && stored_edges >= SLOTS) begin
      res.status = est_pkg::ST_FULL;
    end else begin
      if (slot < 0) begin
        slot = stored_edges;
        stored_edges++;
        slot_src[slot]  = req.src_node;
        slot_dst[slot]  = req.dst_node;
        slot_hits[slot] = '0;
        slot_mean[slot] = '0;
        slot_conf[slot] = '0;
      end
      n = 64'(slot_hits[slot]);
      if (n != COUNT_TOP)
        n = n + 64'd1;
      acc = 64'(slot_mean[slot]) * (n - 64'd1) + 64'(req.latency_sample);
      slot_mean[slot] = 32'(acc / n);
      acc = (n * CONF_NUM) / (n + CONF_ADD);
      if (acc > CONF_LIMIT)
        acc = CONF_LIMIT;
      slot_hits[slot] = n[31:0];
      slot_conf[slot] = acc[14:0];
      res.status = est_pkg::ST_OK;
    end
    if (res.status == est_pkg::ST_OK) begin
      res.hit_count    = slot_hits[slot];
      res.mean_latency = slot_mean[slot];
      res.confidence   = slot_conf[slot];
    end
    res.entries_used = 7'(stored_edges);
    return res;
  endfunction

  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    est_pkg::out_item_t want;
    if (rst) begin
      stored_edges = 0;
      queued_stats.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (queued_stats.size() == 0) begin
          fail_count++;
          $display("%0t: status mismatch, expected no result, got %0h",
                   $time, out_data.status);
        end else begin
          want = queued_stats.pop_front();
          flag_field("status", 32'(want.status), 32'(out_data.status));
          flag_field("hit_count", want.hit_count, out_data.hit_count);
          flag_field("mean_latency", want.mean_latency, out_data.mean_latency);
          flag_field("confidence", 32'(want.confidence), 32'(out_data.confidence));
          flag_field("entries_used", 32'(want.entries_used), 32'(out_data.entries_used));
          results_checked++;
        end
      end
      if (in_valid && in_ready)
        queued_stats.push_back(edge_stats_after(in_data));
    end
    pending    = queued_stats.size();
    table_fill = stored_edges;
  end

endmodule

/* tb/edge_statistics_table_tb.sv */
`timescale 1ns / 1ps
// Top of the edge statistics table testbench: clock, reset, stimulus, back-pressure and verdict.
module edge_statistics_table_tb;

  localparam int TABLE_SLOTS = 64;
  // Keys drawn by the random part; more than the table holds so that it fills up
  // and later new edges are turned away as table full.
  localparam int POOL_SIZE   = 96;
  localparam int RANDOM_ITEMS = 1800;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  est_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  est_pkg::out_item_t out_data;

  int fail_count;
  int pending;
  int results_checked;
  int table_fill;

  // While calm is set neither side inserts idle cycles, so that back-to-back
  // transactions are exercised as well as the gapped ones.
  logic        calm;
  int          observes_sent;
  int          lookups_sent;
  logic [15:0] pool_src [POOL_SIZE];
  logic [15:0] pool_dst [POOL_SIZE];

  edge_statistics_table #(
    .EDGE_ENTRIES(TABLE_SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  edge_table_checker #(
    .SLOTS(TABLE_SLOTS)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .table_fill     (table_fill)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one transaction. It is entered and left at a falling edge. An optional
  // idle stretch comes first; then the payload is held until the block takes it.
  // Handshake signals are read right after the rising edge, before the block's
  // registers have moved, so the check sees the values the edge acted on.
  task automatic send_item(input logic mode, input logic [15:0] s, input logic [15:0] d,
                           input logic [31:0] lat);
    est_pkg::in_item_t item;
    int                gap;
    item.mode           = mode;
    item.src_node       = s;
    item.dst_node       = d;
    item.latency_sample = lat;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (mode == est_pkg::MODE_OBSERVE)
      observes_sent++;
    else
      lookups_sent++;
  endtask

  // Withdraws the offer and holds the sender back until every result issued so
  // far has been collected.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
  endtask

  // Latencies mix full-range values, small values and the two extremes, so the
  // running mean sees both large products and fine truncation.
  function automatic logic [31:0] pick_latency();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 1000);
      2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom_range(0, 65535) << $urandom_range(0, 16);
    endcase
  endfunction

  // Result side: before each result it draws a stall, then keeps ready high
  // until a transaction goes through. The stall is independent of out_valid,
  // so it lands on every phase of the block's work.
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst)
      @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int          pick;
    int          k;
    logic [15:0] s;
    logic [15:0] d;
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    calm          = 1'b0;
    observes_sent = 0;
    lookups_sent  = 0;

    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_src[i] = 16'($urandom_range(0, 65535));
      do pool_dst[i] = 16'($urandom_range(0, 65535)); while (pool_dst[i] == pool_src[i]);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Lookups on the empty table, including a self edge, must
    // report not found.
    send_item(est_pkg::MODE_LOOKUP,  16'h0000, 16'h0000, 32'h0);
    send_item(est_pkg::MODE_LOOKUP,  16'h1234, 16'h4321, 32'hFFFF_FFFF);
    // Self edges are refused on observe and leave the table untouched.
    send_item(est_pkg::MODE_OBSERVE, 16'hFFFF, 16'hFFFF, 32'h1234_5678);
    send_item(est_pkg::MODE_OBSERVE, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    // A new edge at the node extremes, then the largest samples: the mean
    // must climb from zero through the truncating average.
    send_item(est_pkg::MODE_OBSERVE, 16'h0000, 16'hFFFF, 32'h0);
    send_item(est_pkg::MODE_OBSERVE, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(est_pkg::MODE_OBSERVE, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    // The reverse direction is a separate edge.
    send_item(est_pkg::MODE_OBSERVE, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
    send_item(est_pkg::MODE_OBSERVE, 16'hFFFF, 16'h0000, 32'h0000_0001);
    send_item(est_pkg::MODE_LOOKUP,  16'h0000, 16'hFFFF, 32'h0);
    send_item(est_pkg::MODE_LOOKUP,  16'hFFFF, 16'h0000, 32'h0);
    send_item(est_pkg::MODE_LOOKUP,  16'hFFFF, 16'hFFFF, 32'h0);
    send_item(est_pkg::MODE_LOOKUP,  16'h0000, 16'h0000, 32'h0);
    // Alternating bit patterns in every field.
    send_item(est_pkg::MODE_OBSERVE, 16'hAAAA, 16'h5555, 32'hAAAA_AAAA);
    send_item(est_pkg::MODE_OBSERVE, 16'h5555, 16'hAAAA, 32'h5555_5555);
    send_item(est_pkg::MODE_OBSERVE, 16'hAAAA, 16'h5555, 32'h5555_5555);
    send_item(est_pkg::MODE_LOOKUP,  16'h5555, 16'hAAAA, 32'hAAAA_AAAA);
    send_item(est_pkg::MODE_LOOKUP,  16'h5555, 16'h5555, 32'h0);

    // Random part. Most traffic hits the key pool so edges build up counts and
    // confidence; the table fills early on and later new keys are refused.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 300 && i < 500) || (i >= 1200 && i < 1400);
      if (i == 900)
        drain_results();
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, POOL_SIZE - 1);
      s    = 16'($urandom_range(0, 65535));
      d    = 16'($urandom_range(0, 65535));
      if (pick < 55)
        send_item(est_pkg::MODE_OBSERVE, pool_src[k], pool_dst[k], pick_latency());
      else if (pick < 70)
        send_item(est_pkg::MODE_LOOKUP, pool_src[k], pool_dst[k], $urandom);
      else if (pick < 78)
        send_item(est_pkg::MODE_OBSERVE, s, s, pick_latency());
      else if (pick < 84)
        send_item(est_pkg::MODE_LOOKUP, s, s, $urandom);
      else if (pick < 92)
        send_item(est_pkg::MODE_LOOKUP, s, d, $urandom);
      else
        send_item(est_pkg::MODE_OBSERVE, s, d, pick_latency());
    end
    calm = 1'b0;

    // Collect every outstanding result, then give the block time to show any
    // stray output before the verdict.
    drain_results();
    repeat (200) @(negedge clk);

    $display("edge_statistics_table_tb: %0d observe and %0d lookup transactions sent,",
             observes_sent, lookups_sent);
    $display("edge_statistics_table_tb: %0d results compared, table held %0d of %0d edges",
             results_checked, table_fill, TABLE_SLOTS);
    if (fail_count == 0)
      $display("edge_statistics_table_tb: done, clean");
    else
      $display("edge_statistics_table_tb: done, errors");
    $finish;
  end

  // Watchdog: a correct run needs well under a fifth of this time.
  initial begin : watchdog
    #(15_000_000);
    $display("edge_statistics_table_tb: done, errors");
    $finish;
  end

endmodule
